>>> design/kle_pkg.sv
// Package with shared constants, types and the controller state encoding for the line editor.
`default_nettype none
package kle_pkg;

  localparam int DEPTH_DEF = 64;

  localparam logic [7:0] KEY_LEFT  = 8'h3C;
  localparam logic [7:0] KEY_RIGHT = 8'h3E;
  localparam logic [7:0] KEY_BACK  = 8'h2D;

  localparam logic ACT_KEY   = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REWIND,
    ST_STREAM,
    ST_EMPTY
  } kle_state_t;

  typedef struct packed {
    logic b_push;
    logic b_pop;
    logic a_push;
    logic a_pop;
  } kle_cell_ctl_t;

endpackage
`default_nettype wire

>>> design/kle_cell.sv
// One cell of the gap buffer: holds one level of the before stack and one of the after stack.
`default_nettype none
module kle_cell
  import kle_pkg::*;
(
  input  wire logic          clk,
  input  wire kle_cell_ctl_t ctl,
  input  wire logic [7:0]    b_lo_in,
  input  wire logic [7:0]    b_hi_in,
  input  wire logic [7:0]    a_lo_in,
  input  wire logic [7:0]    a_hi_in,
  output logic      [7:0]    b_q,
  output logic      [7:0]    a_q
);

  logic [7:0] b_r;
  logic [7:0] a_r;

  always_ff @(posedge clk) begin
    if (ctl.b_push) begin
      b_r <= b_lo_in;
    end else if (ctl.b_pop) begin
      b_r <= b_hi_in;
    end
    if (ctl.a_push) begin
      a_r <= a_lo_in;
    end else if (ctl.a_pop) begin
      a_r <= a_hi_in;
    end
  end

  assign b_q = b_r;
  assign a_q = a_r;

endmodule
`default_nettype wire

>>> design/keystroke_line_editor.sv
// Top level of the keystroke line editor: controller, row of stack cells and output register.
// The line is held as two stacks in a row of DEPTH cells whose tops sit at cell 0, so every
// edit shifts the row by one place. A keystroke word leaves the controller idle, so input stays
// ready for the next word. A flush word first walks the cursor back to the start, one character
// at a time, then sends one character per cycle from cell 0 while the output is not stalled;
// input is held off until the flush is done, and an empty line gives a single zero last word.
// Input is accepted again once the last word of a flush is in the output register. Inserts
// into a full line are dropped and flagged until the next flush.
`default_nettype none
module keystroke_line_editor
  import kle_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] key_byte
  input  wire logic       in_tuser,   // [0] action
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // [7:0] out_char
  output logic            out_tlast,
  output logic      [1:0] out_tuser   // [0] empty_res, [1] overflowed
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DEPTH_TOT = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  kle_state_t    state_r, state_nxt;
  logic [CW-1:0] bc_r, bc_nxt;
  logic [CW-1:0] ac_r, ac_nxt;
  logic          ovf_r, ovf_nxt;
  logic          ovld_r, ovld_nxt;
  logic [7:0]    ochar_r, ochar_nxt;
  logic          olast_r, olast_nxt;
  logic          oempty_r, oempty_nxt;
  logic          oovf_r, oovf_nxt;

  kle_cell_ctl_t ctl;
  logic [7:0]    b_new;
  logic [7:0]    a_new;
  logic [7:0]    b_q [DEPTH];
  logic [7:0]    a_q [DEPTH];

  logic          in_acc;
  logic          out_free;
  logic [CW:0]   total;
  logic [7:0]    key_byte;
  logic          action;

  assign key_byte = in_tdata;
  assign action   = in_tuser;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !ovld_r || out_tready;
  assign total    = {1'b0, bc_r} + {1'b0, ac_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && action == ACT_FLUSH) begin
          if (total == '0) begin
            state_nxt = ST_EMPTY;
          end else if (bc_r != '0) begin
            state_nxt = ST_REWIND;
          end else begin
            state_nxt = ST_STREAM;
          end
        end
      end
      ST_REWIND: begin
        if (bc_r == CNT_ONE) begin
          state_nxt = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (out_free && ac_r == CNT_ONE) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    b_new      = a_q[0];
    a_new      = b_q[0];
    bc_nxt     = bc_r;
    ac_nxt     = ac_r;
    ovf_nxt    = ovf_r;
    ovld_nxt   = out_tready ? 1'b0 : ovld_r;
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    oempty_nxt = oempty_r;
    oovf_nxt   = oovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && action == ACT_KEY) begin
          case (key_byte)
            KEY_LEFT: begin
              if (bc_r != '0 && {1'b0, ac_r} != DEPTH_TOT) begin
                ctl.b_pop  = 1'b1;
                ctl.a_push = 1'b1;
                bc_nxt     = bc_r - CNT_ONE;
                ac_nxt     = ac_r + CNT_ONE;
              end
            end
            KEY_RIGHT: begin
              if (ac_r != '0 && {1'b0, bc_r} != DEPTH_TOT) begin
                ctl.a_pop  = 1'b1;
                ctl.b_push = 1'b1;
                ac_nxt     = ac_r - CNT_ONE;
                bc_nxt     = bc_r + CNT_ONE;
              end
            end
            KEY_BACK: begin
              if (bc_r != '0) begin
                ctl.b_pop = 1'b1;
                bc_nxt    = bc_r - CNT_ONE;
              end
            end
            default: begin
              if (total < DEPTH_TOT) begin
                ctl.b_push = 1'b1;
                b_new      = key_byte;
                bc_nxt     = bc_r + CNT_ONE;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      ST_REWIND: begin
        ctl.b_pop  = 1'b1;
        ctl.a_push = 1'b1;
        bc_nxt     = bc_r - CNT_ONE;
        ac_nxt     = ac_r + CNT_ONE;
      end
      ST_STREAM: begin
        if (out_free) begin
          ctl.a_pop  = 1'b1;
          ac_nxt     = ac_r - CNT_ONE;
          ovld_nxt   = 1'b1;
          ochar_nxt  = a_q[0];
          olast_nxt  = (ac_r == CNT_ONE);
          oempty_nxt = 1'b0;
          oovf_nxt   = ovf_r;
          if (ac_r == CNT_ONE) begin
            ovf_nxt = 1'b0;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          ovld_nxt   = 1'b1;
          ochar_nxt  = '0;
          olast_nxt  = 1'b1;
          oempty_nxt = 1'b1;
          oovf_nxt   = ovf_r;
          ovf_nxt    = 1'b0;
        end
      end
      default: begin
        ovld_nxt = ovld_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bc_r    <= '0;
      ac_r    <= '0;
      ovf_r   <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bc_r    <= bc_nxt;
      ac_r    <= ac_nxt;
      ovf_r   <= ovf_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ochar_r  <= ochar_nxt;
    olast_r  <= olast_nxt;
    oempty_r <= oempty_nxt;
    oovf_r   <= oovf_nxt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] b_lo;
    logic [7:0] b_hi;
    logic [7:0] a_lo;
    logic [7:0] a_hi;
    if (i == 0) begin : g_first
      assign b_lo = b_new;
      assign a_lo = a_new;
    end else begin : g_mid
      assign b_lo = b_q[i-1];
      assign a_lo = a_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign b_hi = '0;
      assign a_hi = '0;
    end else begin : g_inner
      assign b_hi = b_q[i+1];
      assign a_hi = a_q[i+1];
    end
    kle_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .b_lo_in (b_lo),
      .b_hi_in (b_hi),
      .a_lo_in (a_lo),
      .a_hi_in (a_hi),
      .b_q     (b_q[i]),
      .a_q     (a_q[i])
    );
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = {oovf_r, oempty_r};

endmodule
`default_nettype wire

>>> design/kle_check.sv
// Port-level checker for the line editor and its bind to the top level.
`default_nettype none
module kle_check (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       in_tuser,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata == 8'h00)
    else $error("empty-line word is not a zero last word");

  a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input taken right after a flush word");

  a_key_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("keystroke produced an output word");

endmodule

bind keystroke_line_editor kle_check u_kle_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the keystroke line editor with a gap-buffer line predictor.
`default_nettype none
module tb_top;
  import kle_pkg::*;

  localparam int LINE_MAX = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 400;
  localparam int WORDS_PER_PHASE = 90;
  localparam int DRAIN_CYCLES = 2 * LINE_MAX + 16;

  class line_scoreboard;
    typedef struct {
      logic [7:0] ch;
      logic       last;
      logic       empty_res;
      logic       ovf;
    } line_word_t;

    logic [7:0] left_chars[LINE_MAX];
    logic [7:0] right_chars[LINE_MAX];
    int left_n = 0;
    int right_n = 0;
    bit ovf_seen = 1'b0;
    line_word_t expected_words[$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int flushes = 0;
    int overflow_lines = 0;

    function void add_word(logic [7:0] ch, logic last, logic empty_res);
      line_word_t w;
      w.ch = ch;
      w.last = last;
      w.empty_res = empty_res;
      w.ovf = ovf_seen;
      expected_words.push_back(w);
    endfunction

    function void note_input(logic act, logic [7:0] key);
      int i;
      int total;
      words_in++;
      if (act == ACT_KEY) begin
        if (key == KEY_LEFT) begin
          if (left_n > 0) begin
            left_n--;
            right_chars[right_n] = left_chars[left_n];
            right_n++;
          end
        end else if (key == KEY_RIGHT) begin
          if (right_n > 0) begin
            right_n--;
            left_chars[left_n] = right_chars[right_n];
            left_n++;
          end
        end else if (key == KEY_BACK) begin
          if (left_n > 0) left_n--;
        end else if (left_n + right_n < LINE_MAX) begin
          left_chars[left_n] = key;
          left_n++;
        end else begin
          ovf_seen = 1'b1;
        end
      end else begin
        flushes++;
        if (ovf_seen) overflow_lines++;
        total = left_n + right_n;
        if (total == 0) begin
          add_word(8'h00, 1'b1, 1'b1);
        end else begin
          for (i = 0; i < left_n; i++) add_word(left_chars[i], i + 1 == total, 1'b0);
          for (i = right_n - 1; i >= 0; i--) add_word(right_chars[i], i == 0, 1'b0);
        end
        left_n = 0;
        right_n = 0;
        ovf_seen = 1'b0;
      end
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_result(logic [7:0] ch, logic last, logic [1:0] user);
      line_word_t w;
      words_out++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual char %h last %b user %b",
                 $time, ch, last, user);
      end else begin
        w = expected_words.pop_front();
        if (ch !== w.ch) report("out_char", w.ch, ch);
        if (last !== w.last) report("last", w.last, last);
        if (user[0] !== w.empty_res) report("empty_res", w.empty_res, user[0]);
        if (user[1] !== w.ovf) report("overflowed", w.ovf, user[1]);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;

  line_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int cycles = 0;

  keystroke_line_editor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(input logic act, input logic [7:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= key;
    in_tuser <= act;
    do @(posedge clk); while (!in_tready);
    sb.note_input(act, key);
  endtask

  task automatic edit_line(input bit fill);
    int n;
    int r;
    int inserts;
    logic [7:0] k;
    if (fill) begin
      inserts = LINE_MAX + $urandom_range(0, 6);
      while (inserts > 0) begin
        if ($urandom_range(99) < 15) begin
          send_word(ACT_KEY, $urandom_range(1) ? KEY_LEFT : KEY_RIGHT);
        end else begin
          do k = 8'($urandom); while (k == KEY_LEFT || k == KEY_RIGHT || k == KEY_BACK);
          send_word(ACT_KEY, k);
          inserts--;
        end
      end
    end else begin
      n = $urandom_range(24);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 20) k = KEY_LEFT;
        else if (r < 32) k = KEY_RIGHT;
        else if (r < 45) k = KEY_BACK;
        else k = 8'($urandom);
        send_word(ACT_KEY, k);
      end
    end
    send_word(ACT_FLUSH, 8'($urandom));
  endtask

  initial begin
    int phase;
    int target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty line, cursor moves and backspace at the edges of an empty line.
    send_word(ACT_FLUSH, 8'hFF);
    send_word(ACT_KEY, KEY_LEFT);
    send_word(ACT_KEY, KEY_RIGHT);
    send_word(ACT_KEY, KEY_BACK);
    send_word(ACT_FLUSH, KEY_LEFT);
    // Short line with edits in the middle and at both ends.
    send_word(ACT_KEY, 8'h00);
    send_word(ACT_KEY, 8'hFF);
    send_word(ACT_KEY, 8'h41);
    send_word(ACT_KEY, KEY_LEFT);
    send_word(ACT_KEY, KEY_LEFT);
    send_word(ACT_KEY, 8'h80);
    send_word(ACT_KEY, KEY_RIGHT);
    send_word(ACT_KEY, KEY_RIGHT);
    send_word(ACT_KEY, KEY_RIGHT);
    send_word(ACT_KEY, KEY_BACK);
    send_word(ACT_KEY, KEY_LEFT);
    send_word(ACT_KEY, KEY_LEFT);
    send_word(ACT_KEY, KEY_LEFT);
    send_word(ACT_KEY, KEY_LEFT);
    send_word(ACT_KEY, KEY_BACK);
    send_word(ACT_KEY, 8'h7F);
    send_word(ACT_FLUSH, KEY_BACK);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 48;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 48;
        end
        default: begin
          send_idle_pct = 34;
          recv_stall_pct = 34;
        end
      endcase
      target = sb.words_in + WORDS_PER_PHASE;
      if (phase == 0) begin
        hold_left = HOLD_CYCLES;
        edit_line(1'b1);
      end
      while (sb.words_in < target) edit_line($urandom_range(11) == 0);
    end
    in_tvalid <= 1'b0;

    recv_stall_pct = 0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d keystroke and flush words, %0d flushes, %0d of them after a dropped insert.",
             sb.words_in, sb.flushes, sb.overflow_lines);
    $display("Checked %0d output words, %0d mismatches.", sb.words_out, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
